>>> sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> sv/spp_pkg.sv
// package: widths, sine and colour-shift quarter tables, mask geometry, gradient pairs
package spp_pkg;

	localparam int FRAME_W  = 9;
	localparam int COLUMN_W = 7;
	localparam int ROW_W    = 7;
	localparam int BYTE_W   = 8;

	localparam int SINE_DEPTH     = 512;
	localparam int SHIFT_DEPTH    = 256;
	localparam int GRADIENT_STEPS = 65;
	localparam int MASK_ROWS      = 21;

	localparam int SINE_AW   = $clog2(SINE_DEPTH);
	localparam int SHIFT_AW  = $clog2(SHIFT_DEPTH);
	localparam int SINE_QTR  = SINE_DEPTH / 4;
	localparam int SHIFT_QTR = SHIFT_DEPTH / 4;
	localparam int SINE_AMP  = 32;
	localparam int SHIFT_AMP = 132;

	// sine value 0..64, shift value 0..264, sum of all five 0..520
	localparam int SINE_W  = 7;
	localparam int SHIFT_W = 9;
	localparam int SUM_W   = 10;
	localparam int GRAD_W  = SUM_W - 3;

	localparam int PAIR_COUNT = 65;
	localparam int IDX_MAX    = (GRADIENT_STEPS < PAIR_COUNT ? GRADIENT_STEPS : PAIR_COUNT) - 1;

	localparam int MASK_TOP  = 38;
	localparam int GEO_ROWS  = 21;
	localparam int GEO_AW    = $clog2(GEO_ROWS);
	localparam int ROWS_USED = (MASK_ROWS < GEO_ROWS) ? MASK_ROWS : GEO_ROWS;

	localparam real HALF_PI    = 1.5707963267948966;
	localparam real SINE_STEP  = HALF_PI / SINE_QTR;
	localparam real SHIFT_STEP = HALF_PI / SHIFT_QTR;

	typedef logic [15:0] sine_q_t [0:SINE_QTR];
	typedef logic [15:0] shift_q_t [0:SHIFT_QTR];

	typedef struct packed {
		logic covered;
		logic border;
	} mask_t;

	// quarter-wave entry: bit 15 says the product has a fraction, low bits hold its floor
	function automatic logic [15:0] quarter_entry(int r, int quarter, real step, real amp);
		real p;
		int  fl;
		logic up;
		if (r == 0) begin
			return '0;
		end
		if (r == quarter) begin
			return 16'($rtoi(amp));
		end
		p  = amp * $sin(step * r);
		fl = $rtoi(p);
		up = (p > $itor(fl));
		return {up, 15'(fl)};
	endfunction

	function automatic sine_q_t build_sine_q();
		sine_q_t t;
		for (int r = 0; r <= SINE_QTR; r++) begin
			t[r] = quarter_entry(r, SINE_QTR, SINE_STEP, real'(SINE_AMP));
		end
		return t;
	endfunction

	function automatic shift_q_t build_shift_q();
		shift_q_t t;
		for (int r = 0; r <= SHIFT_QTR; r++) begin
			t[r] = quarter_entry(r, SHIFT_QTR, SHIFT_STEP, real'(SHIFT_AMP));
		end
		return t;
	endfunction

	localparam sine_q_t  SINE_Q  = build_sine_q();
	localparam shift_q_t SHIFT_Q = build_shift_q();

	// per mask row: two half-open spans of 2x+1
	localparam logic [6:0] MASK_GEO [GEO_ROWS][4] = '{
		'{7'd45, 7'd51, 7'd73, 7'd87}, '{7'd41, 7'd57, 7'd71, 7'd91},
		'{7'd39, 7'd59, 7'd69, 7'd95}, '{7'd39, 7'd59, 7'd67, 7'd95},
		'{7'd37, 7'd61, 7'd67, 7'd97}, '{7'd37, 7'd61, 7'd67, 7'd97},
		'{7'd37, 7'd61, 7'd67, 7'd97}, '{7'd37, 7'd61, 7'd67, 7'd99},
		'{7'd37, 7'd61, 7'd69, 7'd99}, '{7'd37, 7'd59, 7'd69, 7'd99},
		'{7'd37, 7'd59, 7'd69, 7'd99}, '{7'd37, 7'd59, 7'd71, 7'd99},
		'{7'd37, 7'd57, 7'd71, 7'd99}, '{7'd37, 7'd57, 7'd71, 7'd99},
		'{7'd39, 7'd57, 7'd73, 7'd99}, '{7'd39, 7'd55, 7'd73, 7'd99},
		'{7'd39, 7'd55, 7'd75, 7'd97}, '{7'd41, 7'd53, 7'd77, 7'd97},
		'{7'd41, 7'd53, 7'd79, 7'd95}, '{7'd43, 7'd51, 7'd81, 7'd95},
		'{7'd45, 7'd49, 7'd83, 7'd93}};

	// attribute in the high byte, character in the low byte; second row for edge cells
	localparam logic [15:0] PAIR_ROM [2][PAIR_COUNT] = '{
		'{16'h00b1, 16'h00b1, 16'h00b1, 16'h00b1, 16'h00b1, 16'h00b1, 16'h00b1, 16'h00b1,
		  16'h00b1, 16'h08b0, 16'h08b1, 16'h80b0, 16'h88b1, 16'h84b0, 16'h84b1, 16'h48b0,
		  16'h44b1, 16'h45b0, 16'h45b1, 16'h54b0, 16'h55b1, 16'h59b0, 16'h59b1, 16'h95b0,
		  16'h99b1, 16'h93b0, 16'h93b1, 16'h39b0, 16'h33b1, 16'h3ab0, 16'h3ab1, 16'ha3b0,
		  16'haab1, 16'haeb0, 16'haeb1, 16'heab0, 16'heeb1, 16'hefb0, 16'hefb1, 16'hfeb0,
		  16'hffb1, 16'hfbb0, 16'hfbb1, 16'hbfb0, 16'hbbb1, 16'hbdb0, 16'hbdb1, 16'hdbb0,
		  16'hddb1, 16'hd6b0, 16'hd6b1, 16'h6db0, 16'h66b1, 16'h64b0, 16'h64b1, 16'h46b0,
		  16'h44b1,
		  16'h44b1, 16'h44b1, 16'h44b1, 16'h44b1, 16'h44b1, 16'h44b1, 16'h44b1, 16'h44b1},
		'{16'h00b0, 16'h00b0, 16'h00b0, 16'h00b0, 16'h00b0, 16'h00b0, 16'h00b0, 16'h00b0,
		  16'h00b0, 16'h00b0, 16'h08b0, 16'h08b0, 16'h08b1, 16'h08b1, 16'h08b1, 16'h04b1,
		  16'h04b1, 16'h04b1, 16'h04b1, 16'h05b1, 16'h05b1, 16'h05b1, 16'h05b1, 16'h09b1,
		  16'h09b1, 16'h09b1, 16'h09b1, 16'h03b1, 16'h03b1, 16'h03b1, 16'h03b1, 16'h0ab1,
		  16'h0ab1, 16'h0ab1, 16'h0ab1, 16'h0eb1, 16'h0eb1, 16'h0eb1, 16'h0eb1, 16'h0fb1,
		  16'h0fb1, 16'h0fb1, 16'h0bb1, 16'h0bb1, 16'h0bb1, 16'h0bb1, 16'h0db1, 16'h0db1,
		  16'h0db1, 16'h0db1, 16'h06b1, 16'h06b1, 16'h06b1, 16'h06b1, 16'h04b1, 16'h04b1,
		  16'h04b1,
		  16'h04b1, 16'h04b1, 16'h04b1, 16'h04b1, 16'h04b1, 16'h04b1, 16'h04b1, 16'h04b1}};

endpackage

>>> sv/spp_mask.sv
// mask membership and edge test for one character cell
module spp_mask (
	input  logic [spp_pkg::COLUMN_W-1:0] column,
	input  logic [spp_pkg::ROW_W-1:0]    row,
	output spp_pkg::mask_t               mask
);
	import spp_pkg::*;

	// x and y may step one cell off the screen on either side
	function automatic logic in_mask(logic signed [8:0] x, logic signed [8:0] y);
		logic signed [8:0] r;
		logic signed [9:0] xx;
		logic [GEO_AW-1:0] ri;
		logic in_a;
		logic in_b;
		r  = y - 9'(MASK_TOP);
		xx = {x, 1'b1};
		if (r[8] || (r[7:0] >= 8'(ROWS_USED))) begin
			return 1'b0;
		end
		ri   = r[GEO_AW-1:0];
		in_a = (xx >= $signed({3'b000, MASK_GEO[ri][0]})) &&
		       (xx <  $signed({3'b000, MASK_GEO[ri][1]}));
		in_b = (xx >= $signed({3'b000, MASK_GEO[ri][2]})) &&
		       (xx <  $signed({3'b000, MASK_GEO[ri][3]}));
		return in_a || in_b;
	endfunction

	logic signed [8:0] x9;
	logic signed [8:0] y9;
	logic              all_nbrs_in;

	assign x9 = $signed(9'(column));
	assign y9 = $signed(9'(row));

	assign all_nbrs_in = in_mask(x9 - 9'sd1, y9) && in_mask(x9 + 9'sd1, y9) &&
	                     in_mask(x9, y9 - 9'sd1) && in_mask(x9, y9 + 9'sd1);

	assign mask.covered = in_mask(x9, y9);
	assign mask.border  = mask.covered && !all_nbrs_in;

endmodule

>>> sv/spp_plasma.sv
// plasma value from four sine lookups and one colour-shift lookup, then gradient index
module spp_plasma (
	input  logic [spp_pkg::FRAME_W-1:0]  frame_number,
	input  logic [spp_pkg::COLUMN_W-1:0] column,
	input  logic [spp_pkg::ROW_W-1:0]    row,
	output logic [spp_pkg::GRAD_W-1:0]   grad_idx
);
	import spp_pkg::*;

	// full wave from the quarter table: mirror in odd quadrants, negate in the lower half
	function automatic logic [SINE_W-1:0] sine_val(logic [SINE_AW-1:0] i);
		logic [1:0]          quad;
		logic [SINE_AW-2:0]  r;
		logic [15:0]         e;
		logic [SINE_W-1:0]   fl;
		quad = i[SINE_AW-1 -: 2];
		r    = quad[0] ? (SINE_AW-1)'(SINE_QTR - int'(i[SINE_AW-3:0]))
		               : {1'b0, i[SINE_AW-3:0]};
		e    = SINE_Q[r];
		fl   = e[SINE_W-1:0];
		if (!quad[1]) begin
			return SINE_W'(SINE_AMP) + fl;
		end
		return SINE_W'(SINE_AMP) - fl - SINE_W'(e[15]);
	endfunction

	function automatic logic [SHIFT_W-1:0] shift_val(logic [SHIFT_AW-1:0] i);
		logic [1:0]          quad;
		logic [SHIFT_AW-2:0] r;
		logic [15:0]         e;
		logic [SHIFT_W-1:0]  fl;
		quad = i[SHIFT_AW-1 -: 2];
		r    = quad[0] ? (SHIFT_AW-1)'(SHIFT_QTR - int'(i[SHIFT_AW-3:0]))
		               : {1'b0, i[SHIFT_AW-3:0]};
		e    = SHIFT_Q[r];
		fl   = e[SHIFT_W-1:0];
		if (!quad[1]) begin
			return SHIFT_W'(SHIFT_AMP) + fl;
		end
		return SHIFT_W'(SHIFT_AMP) - fl - SHIFT_W'(e[15]);
	endfunction

	logic [12:0]         f13;
	logic [12:0]         x13;
	logic [12:0]         y13;
	logic [12:0]         phase_a;
	logic [12:0]         phase_b;
	logic [12:0]         phase_c;
	logic [12:0]         phase_d;
	logic [SUM_W-1:0]    v;
	logic [GRAD_W-1:0]   raw_idx;

	assign f13 = 13'(frame_number);
	assign x13 = 13'(column);
	assign y13 = 13'(row);

	// phases wrap modulo the table depth through the low address bits
	assign phase_a = f13 * 13'd16 + y13 * 13'd24;
	assign phase_b = y13 * 13'd3 - f13;
	assign phase_c = f13 * 13'd8 + x13 * 13'd40;
	assign phase_d = f13 * 13'd2 + x13 * 13'd5;

	assign v = SUM_W'(shift_val(frame_number[SHIFT_AW-1:0]))
	         + SUM_W'(sine_val(phase_a[SINE_AW-1:0]))
	         + SUM_W'(sine_val(phase_b[SINE_AW-1:0]))
	         + SUM_W'(sine_val(phase_c[SINE_AW-1:0]))
	         + SUM_W'(sine_val(phase_d[SINE_AW-1:0]));

	assign raw_idx  = v[SUM_W-1:3];
	assign grad_idx = (raw_idx > GRAD_W'(IDX_MAX)) ? GRAD_W'(IDX_MAX) : raw_idx;

endmodule

>>> sv/sine_plasma_pixel_generator_top.sv
// top level: cell register, plasma and mask logic, result register
// a result is offered from the result register once its cell has moved on from the cell register
// throughput: one cell per clock; the only hold-off is a stalled, full result register
// set by the single cell register feeding the result register through the table logic
// reset (arst_n low, asynchronous) empties both stages; the tables are constants
// nothing is built or cleared after reset, the first cell may follow at once
module sine_plasma_pixel_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// cell channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spp_pkg::FRAME_W-1:0]   frame_number,
	input  logic [spp_pkg::COLUMN_W-1:0]  column,
	input  logic [spp_pkg::ROW_W-1:0]     row,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_enable,
	output logic                          edge_cell,
	output logic [spp_pkg::BYTE_W-1:0]    char_byte,
	output logic [spp_pkg::BYTE_W-1:0]    attr_byte
);
	import spp_pkg::*;

	// stage 1: the accepted cell
	logic                 valid_s1;
	logic [FRAME_W-1:0]   frame_s1;
	logic [COLUMN_W-1:0]  column_s1;
	logic [ROW_W-1:0]     row_s1;

	// stage 2: the result waiting to be taken
	logic                 valid_s2;
	logic                 write_enable_s2;
	logic                 edge_cell_s2;
	logic [BYTE_W-1:0]    char_byte_s2;
	logic [BYTE_W-1:0]    attr_byte_s2;

	logic                 advance_s2;
	mask_t                mask;
	logic [GRAD_W-1:0]    grad_idx;
	logic [15:0]          pair;

	// the result register frees up when empty or when its item is taken this cycle
	assign advance_s2 = !valid_s2 || !out_stall;
	// the cell register holds only while its item cannot move on
	assign in_stall   = valid_s1 && !advance_s2;

	// mask membership plus 4-neighbour edge test
	spp_mask u_mask (
		.column (column_s1),
		.row    (row_s1),
		.mask   (mask)
	);

	// plasma sum and clamped gradient index
	spp_plasma u_plasma (
		.frame_number (frame_s1),
		.column       (column_s1),
		.row          (row_s1),
		.grad_idx     (grad_idx)
	);

	// edge cells take the second gradient row
	assign pair = PAIR_ROM[mask.border][grad_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			frame_s1  <= frame_number;
			column_s1 <= column;
			row_s1    <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// a cell outside the mask gives an all-zero item
	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			write_enable_s2 <= mask.covered;
			edge_cell_s2    <= mask.border;
			char_byte_s2    <= mask.covered ? pair[7:0]  : '0;
			attr_byte_s2    <= mask.covered ? pair[15:8] : '0;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = write_enable_s2;
	assign edge_cell    = edge_cell_s2;
	assign char_byte    = char_byte_s2;
	assign attr_byte    = attr_byte_s2;

endmodule

>>> sv/spp_checker.sv
// port-level checker for the plasma cell generator, bound to the top level
`include "assert_macros.svh"

module spp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          write_enable,
	input logic                          edge_cell,
	input logic [spp_pkg::BYTE_W-1:0]    char_byte,
	input logic [spp_pkg::BYTE_W-1:0]    attr_byte
);
	import spp_pkg::*;

	// a cell outside the mask carries nothing
	`ASSERT_IMPLIES(a_outside_zero, clk, arst_n, out_valid && !write_enable, !edge_cell && char_byte == 8'h00 && attr_byte == 8'h00)

	// every gradient pair uses one of the two shade characters
	`ASSERT_IMPLIES(a_shade_char, clk, arst_n, out_valid && write_enable, char_byte == 8'hb0 || char_byte == 8'hb1)

	// the edge row only holds dark-background attributes
	`ASSERT_IMPLIES(a_edge_attr, clk, arst_n, out_valid && edge_cell, write_enable && attr_byte[7:4] == 4'h0)

	// no bubble: a free result side never holds off the cell side
	`ASSERT_IMPLIES(a_no_holdoff, clk, arst_n, !out_stall, !in_stall)

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid)

endmodule

bind sine_plasma_pixel_generator_top spp_checker u_spp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.write_enable (write_enable),
	.edge_cell    (edge_cell),
	.char_byte    (char_byte),
	.attr_byte    (attr_byte)
);
